>>> rtl/core/gmnb_pkg.sv
// Package for the grid mesh normal builder: command codes, status codes, field widths
// and the command and status bundles between the controller and the datapath.
// No dependencies.
package gmnb_pkg;

    localparam int POS_W   = 24;
    localparam int DIFF_W  = 25;
    localparam int SUM_W   = 54;
    localparam int MUL_W   = 29;
    localparam int PROD_W  = 58;
    localparam int SQ_W    = 58;
    localparam int ROOT_W  = 29;
    localparam int REM_W   = 30;
    localparam int NUM_W   = 43;
    localparam int DEN_W   = 29;
    localparam int Q_W     = 17;
    localparam int NORM_W  = 16;
    localparam int TEX_W   = 17;
    localparam int CORN_W  = 12;
    localparam int CFG_W   = 7;
    localparam int NORM_TOP = 27;
    localparam int SQRT_STEPS = 29;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
    localparam logic [Q_W-1:0]   UNIT_ONE  = 17'd16384;

    localparam logic [1:0] FN_LOAD  = 2'd0;
    localparam logic [1:0] FN_BUILD = 2'd1;
    localparam logic [1:0] FN_VERT  = 2'd2;
    localparam logic [1:0] FN_TRI   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_UNBUILT = 2'd2;

    localparam logic CFG_IDX_WIDTH = 1'b0;

    // Multiplier operand selections: three cross-product pairs, then three squares.
    localparam logic [3:0] MS_NX0 = 4'd0;
    localparam logic [3:0] MS_NX1 = 4'd1;
    localparam logic [3:0] MS_NY0 = 4'd2;
    localparam logic [3:0] MS_NY1 = 4'd3;
    localparam logic [3:0] MS_NZ0 = 4'd4;
    localparam logic [3:0] MS_NZ1 = 4'd5;
    localparam logic [3:0] MS_SQ0 = 4'd6;
    localparam logic [3:0] MS_SQ1 = 4'd7;
    localparam logic [3:0] MS_SQ2 = 4'd8;

    // Divider jobs: three normal components, then the two texture coordinates.
    localparam logic [2:0] DS_NX = 3'd0;
    localparam logic [2:0] DS_NY = 3'd1;
    localparam logic [2:0] DS_NZ = 3'd2;
    localparam logic [2:0] DS_U  = 3'd3;
    localparam logic [2:0] DS_V  = 3'd4;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } pos_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } sum_t;

    typedef struct packed {
        logic       latch;
        logic       pos_wr;
        logic       clr_start;
        logic       clr_wr;
        logic       walk_start;
        logic       walk_step;
        logic       pos_rd;
        logic [1:0] rd_sel;
        logic       pos_cap;
        logic [1:0] cap_sel;
        logic       diff_en;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic       ncap_en;
        logic [3:0] ncap_sel;
        logic       sum_rd;
        logic       sum_rd_idx;
        logic       sum_acc;
        logic [1:0] acc_sel;
        logic       sum_cap;
        logic       norm_shift;
        logic       sqrt_step;
        logic       div_load;
        logic       div_step;
        logic       div_store;
        logic [2:0] div_sel;
        logic       set_status;
        logic [1:0] status_code;
        logic       tri_set;
        logic       publish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       range_bad;
        logic       clr_last;
        logic       walk_last;
        logic       m_zero;
        logic       norm_ok;
    } stat_t;

endpackage

>>> rtl/core/grid_mesh_normal_builder.sv
// Top level of the grid mesh normal builder: joins the controller and the datapath.
// Depends on gmnb_pkg, gmnb_ctrl and gmnb_dp.
//
// Commands arrive as beats on the input channel (in_valid, in_stall) and each gives exactly
// one result beat on the output channel (out_valid, out_stall). A beat moves at a rising
// edge where valid is high and stall is low. Configuration (grid width, grid depth) is
// written through cfg_valid/cfg_ready/cfg_index/cfg_data while no command is in flight.
// Items are worked one at a time; the controller sequences a shared multiplier, a 2-bit
// square-root step and a 1-bit divider step around single-port memories.
// Load, triangle read and rejected commands go from decode straight to the result beat.
// Vertex read: alignment shift, square-root steps and five divisions (three normal
// components, then the two texture coordinates); a zero normal does only the last two.
// Build: clear all MAX_COLS*MAX_ROWS normal sums, then walk the triangles, two per cell.
// Reset clears control state and sets both registers to 64; no build is valid afterwards.
// A result waiting under out_stall holds its beat; the next command is still accepted and
// worked, and its result waits until the output register is free.
module grid_mesh_normal_builder
    import gmnb_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               func,
    input  logic [5:0]               col,
    input  logic [5:0]               row,
    input  logic                     half,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [NORM_W-1:0] normal_x,
    output logic signed [NORM_W-1:0] normal_y,
    output logic signed [NORM_W-1:0] normal_z,
    output logic [TEX_W-1:0]         tex_u,
    output logic [TEX_W-1:0]         tex_v,
    output logic [CORN_W-1:0]        corner_a,
    output logic [CORN_W-1:0]        corner_b,
    output logic [CORN_W-1:0]        corner_c,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    cmd_t  cmd;
    stat_t st;
    logic  cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    gmnb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_ready (cfg_ready),
        .cfg_we    (cfg_we),
        .st        (st),
        .cmd       (cmd)
    );

    gmnb_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .func      (func),
        .col       (col),
        .row       (row),
        .half      (half),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .status    (status),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .normal_z  (normal_z),
        .tex_u     (tex_u),
        .tex_v     (tex_v),
        .corner_a  (corner_a),
        .corner_b  (corner_b),
        .corner_c  (corner_c)
    );

endmodule

>>> rtl/core/gmnb_ctrl.sv
// Controller of the grid mesh normal builder: sequences loads, builds and reads.
// Depends on gmnb_pkg; drives the datapath gmnb_dp through cmd_t and reads stat_t.
module gmnb_ctrl
    import gmnb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    output logic  cfg_ready,
    input  logic  cfg_we,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECODE = 13'b0000000000010,
        S_CLR    = 13'b0000000000100,
        S_PRD    = 13'b0000000001000,
        S_DIFF   = 13'b0000000010000,
        S_MUL    = 13'b0000000100000,
        S_ACC    = 13'b0000001000000,
        S_VCAP   = 13'b0000010000000,
        S_NSHIFT = 13'b0000100000000,
        S_SQ     = 13'b0001000000000,
        S_SQRT   = 13'b0010000000000,
        S_DIV    = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] sel_reg, sel_next;
    logic       built_reg, built_next;
    logic       out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sel_next       = sel_reg;
        built_next     = built_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.func == FN_BUILD)
                begin
                    cmd.clr_start = 1'b1;
                    state_next    = S_CLR;
                end
                else if (st.range_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OUTSIDE;
                    state_next      = S_DONE;
                end
                else if (st.func == FN_LOAD)
                begin
                    cmd.pos_wr = 1'b1;
                    state_next = S_DONE;
                end
                else if (!built_reg)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_UNBUILT;
                    state_next      = S_DONE;
                end
                else if (st.func == FN_TRI)
                begin
                    cmd.tri_set = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.sum_rd     = 1'b1;
                    cmd.sum_rd_idx = 1'b1;
                    state_next     = S_VCAP;
                end
            end
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last)
                begin
                    cmd.walk_start = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_PRD;
                end
            end
            S_PRD:
            begin
                if (cnt_reg < 5'd3)
                begin
                    cmd.pos_rd = 1'b1;
                    cmd.rd_sel = cnt_reg[1:0];
                end
                if (cnt_reg != 5'd0)
                begin
                    cmd.pos_cap = 1'b1;
                    cmd.cap_sel = cnt_reg[1:0] - 2'd1;
                end
                if (cnt_reg == 5'd3)
                begin
                    cnt_next   = '0;
                    state_next = S_DIFF;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                cnt_next    = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                if (cnt_reg < 5'd6)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = cnt_reg[3:0];
                end
                if (cnt_reg != 5'd0)
                begin
                    cmd.ncap_en  = 1'b1;
                    cmd.ncap_sel = cnt_reg[3:0] - 4'd1;
                end
                if (cnt_reg == 5'd6)
                begin
                    cnt_next   = '0;
                    state_next = S_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_ACC:
            begin
                if (!cnt_reg[0])
                begin
                    cmd.sum_rd = 1'b1;
                    cmd.rd_sel = cnt_reg[2:1];
                end
                else
                begin
                    cmd.sum_acc = 1'b1;
                    cmd.acc_sel = cnt_reg[2:1];
                end
                if (cnt_reg == 5'd5)
                begin
                    cnt_next = '0;
                    if (st.walk_last)
                    begin
                        built_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.walk_step = 1'b1;
                        state_next    = S_PRD;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_VCAP:
            begin
                cmd.sum_cap = 1'b1;
                state_next  = S_NSHIFT;
            end
            S_NSHIFT:
            begin
                cnt_next = '0;
                if (st.m_zero)
                begin
                    sel_next   = DS_U;
                    state_next = S_DIV;
                end
                else if (st.norm_ok)
                begin
                    state_next = S_SQ;
                end
                else
                begin
                    cmd.norm_shift = 1'b1;
                end
            end
            S_SQ:
            begin
                if (cnt_reg < 5'd3)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MS_SQ0 + cnt_reg[3:0];
                end
                if (cnt_reg != 5'd0)
                begin
                    cmd.ncap_en  = 1'b1;
                    cmd.ncap_sel = MS_SQ0 + cnt_reg[3:0] - 4'd1;
                end
                if (cnt_reg == 5'd3)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    sel_next   = DS_NX;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_DIV:
            begin
                cmd.div_sel = sel_reg;
                if (cnt_reg == 5'd0)
                begin
                    cmd.div_load = 1'b1;
                end
                else if (cnt_reg == 5'(Q_W + 1))
                begin
                    cmd.div_store = 1'b1;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
                if (cnt_reg == 5'(Q_W + 1))
                begin
                    cnt_next = '0;
                    if (sel_reg == DS_V)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        sel_next = sel_reg + 3'd1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            built_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            sel_reg       <= '0;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sel_reg       <= sel_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/gmnb_dp.sv
// Datapath of the grid mesh normal builder: position and normal-sum memories, the shared
// multiplier, square-root and divider steps, and the result registers.
// Depends on gmnb_pkg; every action but a configuration write is started by a cmd_t from gmnb_ctrl.
module gmnb_dp
    import gmnb_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    st,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic [1:0]               func,
    input  logic [5:0]               col,
    input  logic [5:0]               row,
    input  logic                     half,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    output logic [1:0]               status,
    output logic signed [NORM_W-1:0] normal_x,
    output logic signed [NORM_W-1:0] normal_y,
    output logic signed [NORM_W-1:0] normal_z,
    output logic [TEX_W-1:0]         tex_u,
    output logic [TEX_W-1:0]         tex_v,
    output logic [CORN_W-1:0]        corner_a,
    output logic [CORN_W-1:0]        corner_b,
    output logic [CORN_W-1:0]        corner_c
);

    localparam int NVERT = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(NVERT);
    localparam int WW    = $clog2(MAX_COLS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);

    logic [CFG_W-1:0] gw_reg, gd_reg;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    d_eff;

    logic [1:0]              func_reg;
    logic [5:0]              col_reg, row_reg;
    logic                    half_reg;
    pos_t                    pin_reg;
    logic [AW-1:0]           idx;

    pos_t                    pos_mem_reg [NVERT];
    pos_t                    pos_rd_reg;
    pos_t                    p_reg [3];
    sum_t                    sum_mem_reg [NVERT];
    sum_t                    sum_rd_reg;
    sum_t                    sum_add;

    logic [AW-1:0]           clr_addr_reg;
    logic [WW-1:0]           wc_reg;
    logic [HW-1:0]           wr_reg;
    logic [AW-1:0]           wi_reg;
    logic                    tri_reg;
    logic [AW-1:0]           cor0, cor1, cor2, rd_addr, acc_addr;

    logic signed [DIFF_W-1:0] ex_reg, ey_reg, ez_reg, fx_reg, fy_reg, fz_reg;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  n_reg [3];

    logic [SUM_W-1:0]        m_reg [3];
    logic                    s_neg_reg [3];
    logic [SUM_W-1:0]        m_hi;
    logic [SQ_W-1:0]         sq_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [REM_W+1:0]        rem_try, root_try;

    logic [NUM_W-1:0]        num;
    logic [DEN_W-1:0]        den;
    logic [DEN_W-1:0]        rdiv_reg, den_reg;
    logic [Q_W-1:0]          nsh_reg, q_reg, q_clamp;
    logic [DEN_W:0]          rdiv_try;
    logic signed [NORM_W-1:0] q_signed;
    logic                    q_neg;

    logic [1:0]               res_status_reg;
    logic signed [NORM_W-1:0] res_n_reg [3];
    logic [TEX_W-1:0]         res_u_reg, res_v_reg;
    logic [CORN_W-1:0]        res_a_reg, res_b_reg, res_c_reg;

    // Configuration and effective grid size.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= CFG_RESET;
            gd_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IDX_WIDTH)
            begin
                gw_reg <= cfg_data;
            end
            else
            begin
                gd_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (gw_reg < 7'd2)
        begin
            w_eff = WW'(2);
        end
        else if (32'(gw_reg) > MAX_COLS)
        begin
            w_eff = WW'(MAX_COLS);
        end
        else
        begin
            w_eff = WW'(gw_reg);
        end
        if (gd_reg < 7'd2)
        begin
            d_eff = HW'(2);
        end
        else if (32'(gd_reg) > MAX_ROWS)
        begin
            d_eff = HW'(MAX_ROWS);
        end
        else
        begin
            d_eff = HW'(gd_reg);
        end
    end

    // Input beat capture and address checks.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg  <= func;
            col_reg   <= col;
            row_reg   <= row;
            half_reg  <= half;
            pin_reg.x <= pos_x;
            pin_reg.y <= pos_y;
            pin_reg.z <= pos_z;
        end
    end

    assign idx = AW'(32'(row_reg) * 32'(w_eff) + 32'(col_reg));

    always_comb
    begin
        st.func = func_reg;
        if (func_reg == FN_TRI)
        begin
            st.range_bad = (32'(col_reg) + 32'd1 >= 32'(w_eff)) ||
                           (32'(row_reg) + 32'd1 >= 32'(d_eff));
        end
        else
        begin
            st.range_bad = (32'(col_reg) >= 32'(w_eff)) || (32'(row_reg) >= 32'(d_eff));
        end
        st.clr_last  = (clr_addr_reg == AW'(NVERT - 1));
        st.walk_last = tri_reg && (32'(wc_reg) + 32'd2 == 32'(w_eff)) &&
                       (32'(wr_reg) + 32'd2 == 32'(d_eff));
        m_hi         = (m_reg[0] | m_reg[1] | m_reg[2]) >> (NORM_TOP + 1);
        st.m_zero    = ((m_reg[0] | m_reg[1] | m_reg[2]) == '0);
        st.norm_ok   = (m_hi == '0) && (m_reg[0][NORM_TOP] || m_reg[1][NORM_TOP] ||
                                        m_reg[2][NORM_TOP]);
    end

    // Cell walk over the grid and the corners of the current triangle.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_start)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
        if (cmd.walk_start)
        begin
            wc_reg  <= '0;
            wr_reg  <= '0;
            wi_reg  <= '0;
            tri_reg <= 1'b0;
        end
        else if (cmd.walk_step)
        begin
            tri_reg <= !tri_reg;
            if (tri_reg)
            begin
                if (32'(wc_reg) + 32'd2 == 32'(w_eff))
                begin
                    wc_reg <= '0;
                    wr_reg <= wr_reg + HW'(1);
                    wi_reg <= wi_reg + AW'(2);
                end
                else
                begin
                    wc_reg <= wc_reg + WW'(1);
                    wi_reg <= wi_reg + AW'(1);
                end
            end
        end
    end

    always_comb
    begin
        cor0 = AW'(32'(wi_reg) + 32'(w_eff));
        if (!tri_reg)
        begin
            cor1 = AW'(32'(wi_reg) + 32'(w_eff) + 32'd1);
            cor2 = AW'(32'(wi_reg) + 32'd1);
        end
        else
        begin
            cor1 = AW'(32'(wi_reg) + 32'd1);
            cor2 = wi_reg;
        end
        case (cmd.rd_sel)
            2'd0:    rd_addr = cor0;
            2'd1:    rd_addr = cor1;
            default: rd_addr = cor2;
        endcase
        case (cmd.acc_sel)
            2'd0:    acc_addr = cor0;
            2'd1:    acc_addr = cor1;
            default: acc_addr = cor2;
        endcase
    end

    // Position memory.
    always_ff @(posedge clk)
    begin
        if (cmd.pos_wr)
        begin
            pos_mem_reg[idx] <= pin_reg;
        end
        if (cmd.pos_rd)
        begin
            pos_rd_reg <= pos_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos_cap)
        begin
            case (cmd.cap_sel)
                2'd0:    p_reg[0] <= pos_rd_reg;
                2'd1:    p_reg[1] <= pos_rd_reg;
                default: p_reg[2] <= pos_rd_reg;
            endcase
        end
        if (cmd.diff_en)
        begin
            ex_reg <= DIFF_W'(p_reg[1].x) - DIFF_W'(p_reg[0].x);
            ey_reg <= DIFF_W'(p_reg[1].y) - DIFF_W'(p_reg[0].y);
            ez_reg <= DIFF_W'(p_reg[1].z) - DIFF_W'(p_reg[0].z);
            fx_reg <= DIFF_W'(p_reg[2].x) - DIFF_W'(p_reg[1].x);
            fy_reg <= DIFF_W'(p_reg[2].y) - DIFF_W'(p_reg[1].y);
            fz_reg <= DIFF_W'(p_reg[2].z) - DIFF_W'(p_reg[1].z);
        end
    end

    // Shared multiplier for the cross product and the squared magnitudes.
    always_comb
    begin
        case (cmd.mul_sel)
            MS_NX0:
            begin
                mul_a = MUL_W'(ey_reg);
                mul_b = MUL_W'(fz_reg);
            end
            MS_NX1:
            begin
                mul_a = MUL_W'(ez_reg);
                mul_b = MUL_W'(fy_reg);
            end
            MS_NY0:
            begin
                mul_a = MUL_W'(ez_reg);
                mul_b = MUL_W'(fx_reg);
            end
            MS_NY1:
            begin
                mul_a = MUL_W'(ex_reg);
                mul_b = MUL_W'(fz_reg);
            end
            MS_NZ0:
            begin
                mul_a = MUL_W'(ex_reg);
                mul_b = MUL_W'(fy_reg);
            end
            MS_NZ1:
            begin
                mul_a = MUL_W'(ey_reg);
                mul_b = MUL_W'(fx_reg);
            end
            MS_SQ0:
            begin
                mul_a = {1'b0, m_reg[0][NORM_TOP:0]};
                mul_b = {1'b0, m_reg[0][NORM_TOP:0]};
            end
            MS_SQ1:
            begin
                mul_a = {1'b0, m_reg[1][NORM_TOP:0]};
                mul_b = {1'b0, m_reg[1][NORM_TOP:0]};
            end
            default:
            begin
                mul_a = {1'b0, m_reg[2][NORM_TOP:0]};
                mul_b = {1'b0, m_reg[2][NORM_TOP:0]};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.ncap_en)
        begin
            case (cmd.ncap_sel)
                MS_NX0: n_reg[0] <= SUM_W'(prod_reg);
                MS_NX1: n_reg[0] <= n_reg[0] - SUM_W'(prod_reg);
                MS_NY0: n_reg[1] <= SUM_W'(prod_reg);
                MS_NY1: n_reg[1] <= n_reg[1] - SUM_W'(prod_reg);
                MS_NZ0: n_reg[2] <= SUM_W'(prod_reg);
                MS_NZ1: n_reg[2] <= n_reg[2] - SUM_W'(prod_reg);
                MS_SQ0: sq_reg   <= SQ_W'(prod_reg);
                default: sq_reg  <= sq_reg + SQ_W'(prod_reg);
            endcase
        end
        else if (cmd.sqrt_step)
        begin
            sq_reg <= sq_reg << 2;
        end
    end

    // Normal-sum memory: cleared at the start of a build, then read, added to and written.
    always_comb
    begin
        sum_add.x = sum_rd_reg.x + n_reg[0];
        sum_add.y = sum_rd_reg.y + n_reg[1];
        sum_add.z = sum_rd_reg.z + n_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            sum_mem_reg[clr_addr_reg] <= '0;
        end
        else if (cmd.sum_acc)
        begin
            sum_mem_reg[acc_addr] <= sum_add;
        end
        if (cmd.sum_rd)
        begin
            sum_rd_reg <= sum_mem_reg[cmd.sum_rd_idx ? idx : rd_addr];
        end
    end

    // Magnitudes and their shared alignment so that the largest has its top bit at bit 27.
    always_ff @(posedge clk)
    begin
        if (cmd.sum_cap)
        begin
            s_neg_reg[0] <= sum_rd_reg.x[SUM_W-1];
            s_neg_reg[1] <= sum_rd_reg.y[SUM_W-1];
            s_neg_reg[2] <= sum_rd_reg.z[SUM_W-1];
            m_reg[0] <= sum_rd_reg.x[SUM_W-1] ? SUM_W'(-sum_rd_reg.x) : SUM_W'(sum_rd_reg.x);
            m_reg[1] <= sum_rd_reg.y[SUM_W-1] ? SUM_W'(-sum_rd_reg.y) : SUM_W'(sum_rd_reg.y);
            m_reg[2] <= sum_rd_reg.z[SUM_W-1] ? SUM_W'(-sum_rd_reg.z) : SUM_W'(sum_rd_reg.z);
        end
        else if (cmd.norm_shift)
        begin
            if (m_hi != '0)
            begin
                m_reg[0] <= m_reg[0] >> 1;
                m_reg[1] <= m_reg[1] >> 1;
                m_reg[2] <= m_reg[2] >> 1;
            end
            else
            begin
                m_reg[0] <= m_reg[0] << 1;
                m_reg[1] <= m_reg[1] << 1;
                m_reg[2] <= m_reg[2] << 1;
            end
        end
    end

    // Square root, two radicand bits a step.
    assign rem_try  = {rem_reg, sq_reg[SQ_W-1:SQ_W-2]};
    assign root_try = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (cmd.ncap_en && (cmd.ncap_sel == MS_SQ0))
        begin
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (rem_try >= root_try)
            begin
                rem_reg  <= REM_W'(rem_try - root_try);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_try);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Restoring divider, one quotient bit a step.
    always_comb
    begin
        case (cmd.div_sel)
            DS_NX:
            begin
                num = NUM_W'({m_reg[0][NORM_TOP:0], 14'b0}) + NUM_W'(root_reg >> 1);
                den = DEN_W'(root_reg);
            end
            DS_NY:
            begin
                num = NUM_W'({m_reg[1][NORM_TOP:0], 14'b0}) + NUM_W'(root_reg >> 1);
                den = DEN_W'(root_reg);
            end
            DS_NZ:
            begin
                num = NUM_W'({m_reg[2][NORM_TOP:0], 14'b0}) + NUM_W'(root_reg >> 1);
                den = DEN_W'(root_reg);
            end
            DS_U:
            begin
                num = NUM_W'({col_reg, 16'b0}) + NUM_W'((w_eff - WW'(1)) >> 1);
                den = DEN_W'(w_eff - WW'(1));
            end
            default:
            begin
                num = NUM_W'({row_reg, 16'b0}) + NUM_W'((d_eff - HW'(1)) >> 1);
                den = DEN_W'(d_eff - HW'(1));
            end
        endcase
        rdiv_try = {rdiv_reg, nsh_reg[Q_W-1]};
        q_clamp  = (q_reg > UNIT_ONE) ? UNIT_ONE : q_reg;
        case (cmd.div_sel)
            DS_NX:   q_neg = s_neg_reg[0];
            DS_NY:   q_neg = s_neg_reg[1];
            default: q_neg = s_neg_reg[2];
        endcase
        q_signed = q_neg ? -NORM_W'(q_clamp) : NORM_W'(q_clamp);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rdiv_reg <= DEN_W'(num >> Q_W);
            nsh_reg  <= num[Q_W-1:0];
            den_reg  <= den;
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            nsh_reg <= nsh_reg << 1;
            if (rdiv_try >= {1'b0, den_reg})
            begin
                rdiv_reg <= DEN_W'(rdiv_try - {1'b0, den_reg});
                q_reg    <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rdiv_reg <= DEN_W'(rdiv_try);
                q_reg    <= {q_reg[Q_W-2:0], 1'b0};
            end
        end
    end

    // Working result and the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            res_status_reg <= ST_OK;
            res_n_reg[0]   <= '0;
            res_n_reg[1]   <= '0;
            res_n_reg[2]   <= '0;
            res_u_reg      <= '0;
            res_v_reg      <= '0;
            res_a_reg      <= '0;
            res_b_reg      <= '0;
            res_c_reg      <= '0;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end
        if (cmd.tri_set)
        begin
            res_a_reg <= CORN_W'(32'(idx) + 32'(w_eff));
            if (!half_reg)
            begin
                res_b_reg <= CORN_W'(32'(idx) + 32'(w_eff) + 32'd1);
                res_c_reg <= CORN_W'(32'(idx) + 32'd1);
            end
            else
            begin
                res_b_reg <= CORN_W'(32'(idx) + 32'd1);
                res_c_reg <= CORN_W'(idx);
            end
        end
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                DS_NX:   res_n_reg[0] <= q_signed;
                DS_NY:   res_n_reg[1] <= q_signed;
                DS_NZ:   res_n_reg[2] <= q_signed;
                DS_U:    res_u_reg    <= q_reg;
                default: res_v_reg    <= q_reg;
            endcase
        end
        if (cmd.publish)
        begin
            status   <= res_status_reg;
            normal_x <= res_n_reg[0];
            normal_y <= res_n_reg[1];
            normal_z <= res_n_reg[2];
            tex_u    <= res_u_reg;
            tex_v    <= res_v_reg;
            corner_a <= res_a_reg;
            corner_b <= res_b_reg;
            corner_c <= res_c_reg;
        end
    end

endmodule
